// ----- design/fhpc_pkg.sv -----
package fhpc_pkg;

  // Fixed header geometry and check values.
  localparam int unsigned HDR_BYTES         = 48;
  localparam int unsigned W32_BASE          = 4;
  localparam int unsigned W64_BASE          = 16;
  localparam int unsigned N_WORDS           = 3;
  localparam int unsigned MAX_DATAGRAM_DEF  = 65535;
  localparam logic [4:0]  HDR_VERSION       = 5'd2;
  localparam logic [31:0] CRC_INIT          = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY_REFL     = 32'h82F6_3B78;
  localparam logic [31:0] CRC_RESIDUE       = 32'hB798_B438;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_BAD_CRC = 2'd2,
    ST_BAD_VER = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  priority_res;
    logic        end_of_transfer;
    logic        ack_request;
    logic [31:0] frame_number;
    logic [31:0] payload_offset;
    logic [31:0] transfer_size;
    logic [63:0] transfer_number;
    logic [63:0] sender_id;
    logic [63:0] topic_key;
    logic [15:0] payload_length;
  } out_item_t;

  // Contents of the input register as seen by the header stage.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // Reflected CRC-32C update by one byte, eight shift steps.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/fhpc_in_reg.sv -----
module fhpc_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fhpc_pkg::in_item_t in_data,
  input  logic               advance,
  output fhpc_pkg::stage_t   stage
);

  logic               valid_r;
  logic               valid_nxt;
  fhpc_pkg::in_item_t item_r;

  // The register frees up in the same cycle its byte moves on.
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// ----- design/fhpc_hdr.sv -----
module fhpc_hdr #(
  parameter int unsigned MAX_DATAGRAM_BYTES = fhpc_pkg::MAX_DATAGRAM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fhpc_pkg::stage_t    stage,
  input  logic                out_free,
  output logic                advance,
  output logic                res_valid,
  output fhpc_pkg::out_item_t res_data
);

  localparam int unsigned CNT_W = $clog2(MAX_DATAGRAM_BYTES + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] cnt_sat;
  logic [31:0]      crc_r;
  logic [31:0]      crc_nxt;
  logic [31:0]      crc_after;
  logic             in_hdr;
  logic [7:0]       head_r;
  logic [7:0]       flag_r;
  logic [31:0]      w32_r [fhpc_pkg::N_WORDS];
  logic [63:0]      w64_r [fhpc_pkg::N_WORDS];

  // A final byte waits here until the result register can take its result.
  assign advance   = stage.valid && (!stage.item.last_byte || out_free);
  assign res_valid = advance && stage.item.last_byte;

  assign in_hdr    = cnt_r < CNT_W'(fhpc_pkg::HDR_BYTES);
  assign crc_after = in_hdr ? fhpc_pkg::crc32c_byte(crc_r, stage.item.data_byte) : crc_r;
  assign cnt_sat   = (cnt_r == CNT_W'(MAX_DATAGRAM_BYTES)) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    cnt_nxt = cnt_r;
    crc_nxt = crc_r;
    if (advance) begin
      if (stage.item.last_byte) begin
        cnt_nxt = '0;
        crc_nxt = fhpc_pkg::CRC_INIT;
      end else begin
        cnt_nxt = cnt_sat;
        crc_nxt = crc_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      crc_r <= fhpc_pkg::CRC_INIT;
    end else begin
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
    end
  end

  // Every captured byte lane is written once per datagram before it is reported.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (cnt_r == CNT_W'(0)) begin
        head_r <= stage.item.data_byte;
      end
      if (cnt_r == CNT_W'(1)) begin
        flag_r <= stage.item.data_byte;
      end
      for (int w = 0; w < fhpc_pkg::N_WORDS; w++) begin
        for (int k = 0; k < 4; k++) begin
          if (cnt_r == CNT_W'(fhpc_pkg::W32_BASE + 4 * w + k)) begin
            w32_r[w][8*k +: 8] <= stage.item.data_byte;
          end
        end
        for (int k = 0; k < 8; k++) begin
          if (cnt_r == CNT_W'(fhpc_pkg::W64_BASE + 8 * w + k)) begin
            w64_r[w][8*k +: 8] <= stage.item.data_byte;
          end
        end
      end
    end
  end

  // When the status is ok the final byte lies past byte 46, so the
  // registered fields are already complete.
  always_comb begin
    res_data = '0;
    if (cnt_sat < CNT_W'(fhpc_pkg::HDR_BYTES)) begin
      res_data.status = fhpc_pkg::ST_SHORT;
    end else if (crc_after != fhpc_pkg::CRC_RESIDUE) begin
      res_data.status = fhpc_pkg::ST_BAD_CRC;
    end else if (head_r[4:0] != fhpc_pkg::HDR_VERSION) begin
      res_data.status = fhpc_pkg::ST_BAD_VER;
    end else begin
      res_data.status          = fhpc_pkg::ST_OK;
      res_data.priority_res    = head_r[7:5];
      res_data.end_of_transfer = flag_r[0];
      res_data.ack_request     = flag_r[1];
      res_data.frame_number    = w32_r[0];
      res_data.payload_offset  = w32_r[1];
      res_data.transfer_size   = w32_r[2];
      res_data.transfer_number = w64_r[0];
      res_data.sender_id       = w64_r[1];
      res_data.topic_key       = w64_r[2];
      res_data.payload_length  = 16'(cnt_sat - CNT_W'(fhpc_pkg::HDR_BYTES));
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (cnt_r == '0) && (crc_r == fhpc_pkg::CRC_INIT))
    else $error("header state not restored after a final byte");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !stage.item.last_byte && (cnt_r == CNT_W'(MAX_DATAGRAM_BYTES))
    |=> cnt_r == CNT_W'(MAX_DATAGRAM_BYTES))
    else $error("byte count left its saturation value");

endmodule

// ----- design/fhpc_out_reg.sv -----
module fhpc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  fhpc_pkg::out_item_t res_data,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_ready,
  output fhpc_pkg::out_item_t out_data
);

  logic                valid_r;
  logic                valid_nxt;
  fhpc_pkg::out_item_t data_r;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      data_r <= res_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- design/frame_header_parser_crc_check_top.sv -----
// Received-datagram header parser with CRC-32C check. Bytes of one datagram
// enter in order on the in_ channel, one transfer per byte, with last_byte set
// on the final byte. The first 48 bytes form the header: they run through a
// reflected CRC-32C (Castagnoli) and their little-endian fields are captured.
// The final byte of each datagram produces exactly one transfer on the out_
// channel; other bytes produce none. The status reports ok, a datagram shorter
// than the header, a CRC residue mismatch, or a version other than 2, checked
// in that order, and every other field is zero unless the status is ok. The
// payload length counts bytes after the header and saturates at
// MAX_DATAGRAM_BYTES minus 48. The block takes one byte per clock cycle with
// no gaps between datagrams, as long as no final byte is held back. A byte
// is registered in the input register; the header stage then updates the CRC
// with an eight-step bit loop and places the result in the output register,
// from which it is offered to the consumer. A waiting result only holds back
// a following final byte; ordinary bytes keep flowing while it waits.
module frame_header_parser_crc_check_top #(
  parameter int unsigned MAX_DATAGRAM_BYTES = fhpc_pkg::MAX_DATAGRAM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fhpc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fhpc_pkg::out_item_t out_data
);

  // Handshake between the pipeline stages.
  fhpc_pkg::stage_t    stage;
  logic                advance;
  logic                out_free;
  logic                res_valid;
  fhpc_pkg::out_item_t res_data;

  // The input register decouples the byte source from the header stage.
  fhpc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .stage    (stage)
  );

  // The header stage holds the byte count, the running CRC and the captured
  // fields, and forms the result on a final byte.
  fhpc_hdr #(
    .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
  ) u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .out_free  (out_free),
    .advance   (advance),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // The output register holds a result until the consumer takes it.
  fhpc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A new result must never overwrite one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_valid && out_valid && !out_ready))
    else $error("result written over a waiting result");

  // Failed checks report nothing but their status.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != fhpc_pkg::ST_OK)
    |-> (out_data.frame_number == '0) && (out_data.sender_id == '0)
        && (out_data.payload_length == '0) && (out_data.priority_res == '0))
    else $error("nonzero field on a failed header");

endmodule

// ----- verif/frame_header_parser_crc_check_top_tb.sv -----
`timescale 1ns / 100ps

// Testbench for the datagram header parser. Datagrams are streamed one byte
// per transfer, a local model of the parser predicts one result per final
// byte, and every result transfer is checked field by field in order.
module frame_header_parser_crc_check_top_tb;

  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int unsigned QUIET_LIMIT  = 2000;
  // Idle cycles run after the last expected result before the verdict.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_BYTES    = fhpc_pkg::MAX_DATAGRAM_DEF;
  localparam int unsigned N_FIELDS     = 11;

  typedef logic [7:0]  byte_q_t [$];
  typedef logic [63:0] field_vals_t [N_FIELDS];

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  fhpc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  fhpc_pkg::out_item_t out_data;

  frame_header_parser_crc_check_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Header parser model state: byte position, running CRC and captured fields.
  int unsigned rx_count;
  logic [31:0] rx_crc;
  logic [7:0]  rx_head;
  logic [7:0]  rx_flags;
  logic [31:0] rx_word32 [fhpc_pkg::N_WORDS];
  logic [63:0] rx_word64 [fhpc_pkg::N_WORDS];

  // Results predicted from accepted final bytes, oldest first.
  fhpc_pkg::out_item_t pending_results [$];
  int unsigned         mismatch_count;
  int unsigned         quiet_cycles;

  // Idling controls, in percent of cycles.
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reflected CRC-32C, one data bit per step, least significant bit first.
  function automatic logic [31:0] crc32c_update(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) begin
        r = (r >> 1) ^ fhpc_pkg::CRC_POLY_REFL;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  task automatic clear_rx_state();
    rx_count = 0;
    rx_crc   = fhpc_pkg::CRC_INIT;
    rx_head  = '0;
    rx_flags = '0;
    for (int i = 0; i < fhpc_pkg::N_WORDS; i++) begin
      rx_word32[i] = '0;
      rx_word64[i] = '0;
    end
  endtask

  // Feeds one accepted byte into the model. A final byte closes the datagram
  // and queues the result that the parser must report for it.
  task automatic absorb_byte(fhpc_pkg::in_item_t it);
    fhpc_pkg::out_item_t res;
    int unsigned         idx;
    int unsigned         wi;
    idx = rx_count;
    if (idx < fhpc_pkg::HDR_BYTES) begin
      rx_crc = crc32c_update(rx_crc, it.data_byte);
      if (idx == 0) begin
        rx_head = it.data_byte;
      end else if (idx == 1) begin
        rx_flags = it.data_byte;
      end else if (idx >= fhpc_pkg::W32_BASE && idx < fhpc_pkg::W64_BASE) begin
        wi = idx - fhpc_pkg::W32_BASE;
        rx_word32[wi / 4][(wi % 4) * 8 +: 8] = it.data_byte;
      end else if (idx >= fhpc_pkg::W64_BASE
                   && idx < fhpc_pkg::W64_BASE + 8 * fhpc_pkg::N_WORDS) begin
        wi = idx - fhpc_pkg::W64_BASE;
        rx_word64[wi / 8][(wi % 8) * 8 +: 8] = it.data_byte;
      end
    end
    // The count saturates, which caps the reported payload length.
    if (rx_count < MAX_BYTES) begin
      rx_count++;
    end
    if (it.last_byte) begin
      res = '0;
      // Checks apply in a fixed order: length, then CRC, then version.
      if (rx_count < fhpc_pkg::HDR_BYTES) begin
        res.status = fhpc_pkg::ST_SHORT;
      end else if (rx_crc != fhpc_pkg::CRC_RESIDUE) begin
        res.status = fhpc_pkg::ST_BAD_CRC;
      end else if (rx_head[4:0] != fhpc_pkg::HDR_VERSION) begin
        res.status = fhpc_pkg::ST_BAD_VER;
      end else begin
        res.status          = fhpc_pkg::ST_OK;
        res.priority_res    = rx_head[7:5];
        res.end_of_transfer = rx_flags[0];
        res.ack_request     = rx_flags[1];
        res.frame_number    = rx_word32[0];
        res.payload_offset  = rx_word32[1];
        res.transfer_size   = rx_word32[2];
        res.transfer_number = rx_word64[0];
        res.sender_id       = rx_word64[1];
        res.topic_key       = rx_word64[2];
        res.payload_length  = 16'(rx_count - fhpc_pkg::HDR_BYTES);
      end
      pending_results.push_back(res);
      clear_rx_state();
    end
  endtask

  function automatic field_vals_t split_fields(fhpc_pkg::out_item_t r);
    return '{64'(r.status), 64'(r.priority_res), 64'(r.end_of_transfer),
             64'(r.ack_request), 64'(r.frame_number), 64'(r.payload_offset),
             64'(r.transfer_size), r.transfer_number, r.sender_id, r.topic_key,
             64'(r.payload_length)};
  endfunction

  function automatic void check_result(fhpc_pkg::out_item_t want, fhpc_pkg::out_item_t got);
    field_vals_t want_v;
    field_vals_t got_v;
    string       names [N_FIELDS] = '{"status", "priority_res", "end_of_transfer",
                                      "ack_request", "frame_number", "payload_offset",
                                      "transfer_size", "transfer_number", "sender_id",
                                      "topic_key", "payload_length"};
    want_v = split_fields(want);
    got_v  = split_fields(got);
    foreach (want_v[i]) begin
      if (want_v[i] !== got_v[i]) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, names[i], want_v[i],
                 got_v[i]);
        mismatch_count++;
      end
    end
  endfunction

  // One process watches both channels. The model takes each accepted byte
  // before the result side is looked at, though a result always trails its
  // final byte through the input and output registers anyway.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_rx_state();
    end
    if (rst_n && in_valid && in_ready) begin
      absorb_byte(in_data);
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, got %p", $time, out_data);
        mismatch_count++;
      end else begin
        check_result(pending_results.pop_front(), out_data);
      end
    end
  end

  // The receiver drops ready at random; each cycle is drawn on its own, so
  // stalls land on every phase of the parser's work.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a long run of cycles with no transfer at all means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // Offers one byte and returns at the edge where its transfer happens.
  // Each cycle before the offer is idle with the chosen probability.
  task automatic send_byte(logic [7:0] b, logic fin);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: fin};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_datagram(byte_q_t f);
    foreach (f[i]) begin
      send_byte(f[i], i == f.size() - 1);
    end
  endtask

  // Builds a datagram with a 48-byte header. The first 44 bytes are a
  // constant fill, or random when fill is negative; the version bits are
  // forced and the last four bytes carry the CRC-32C of the first 44, low
  // byte first, which leaves the check residue over the whole header.
  // A single flipped bit anywhere in the header then breaks the CRC.
  task automatic build_datagram(output byte_q_t f, input int fill, input logic [4:0] ver,
                                input bit corrupt, input int unsigned payload);
    logic [31:0] c;
    int unsigned pos;
    f = {};
    c = fhpc_pkg::CRC_INIT;
    for (int i = 0; i < fhpc_pkg::HDR_BYTES - 4; i++) begin
      f.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    end
    f[0] = {f[0][7:5], ver};
    foreach (f[i]) begin
      c = crc32c_update(c, f[i]);
    end
    c = ~c;
    for (int i = 0; i < 4; i++) begin
      f.push_back(c[8 * i +: 8]);
    end
    if (corrupt) begin
      pos    = $urandom_range(fhpc_pkg::HDR_BYTES - 1);
      f[pos] = f[pos] ^ (8'h01 << $urandom_range(7));
    end
    repeat (payload) f.push_back(8'($urandom));
  endtask

  task automatic send_runt(int unsigned len, int fill);
    byte_q_t f;
    repeat (len) f.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    send_datagram(f);
  endtask

  // Datagrams shorter than the header, down to a lone final byte. Runs of
  // one-byte datagrams put final bytes back to back.
  task automatic test_runt_datagrams();
    send_runt(1, 8'h00);
    send_runt(1, 8'hFF);
    send_runt(1, -1);
    send_runt(2, -1);
    send_runt(fhpc_pkg::HDR_BYTES - 1, 8'hFF);
    send_runt(fhpc_pkg::HDR_BYTES - 1, 8'h00);
  endtask

  // Well-formed headers with all-zero, all-one, 0x5A-patterned and random fields.
  task automatic test_good_headers();
    byte_q_t f;
    build_datagram(f, 8'h00, fhpc_pkg::HDR_VERSION, 1'b0, 0);
    send_datagram(f);
    build_datagram(f, 8'hFF, fhpc_pkg::HDR_VERSION, 1'b0, 1);
    send_datagram(f);
    build_datagram(f, 8'h5A, fhpc_pkg::HDR_VERSION, 1'b0, 3);
    send_datagram(f);
    build_datagram(f, -1, fhpc_pkg::HDR_VERSION, 1'b0, 7);
    send_datagram(f);
  endtask

  // A bad CRC outranks a wrong version; wrong versions around 2 and at the
  // ends of the five-bit field.
  task automatic test_check_order();
    byte_q_t f;
    build_datagram(f, -1, 5'd3, 1'b1, 2);
    send_datagram(f);
    build_datagram(f, -1, fhpc_pkg::HDR_VERSION, 1'b1, 0);
    send_datagram(f);
    build_datagram(f, -1, 5'd0, 1'b0, 0);
    send_datagram(f);
    build_datagram(f, -1, 5'd31, 1'b0, 4);
    send_datagram(f);
    build_datagram(f, -1, 5'd1, 1'b0, 1);
    send_datagram(f);
  endtask

  // Mostly well-formed datagrams with random content, the rest wrong
  // versions, corrupted headers and runts.
  task automatic test_random_traffic(int unsigned gap_pct, int unsigned stall_pct,
                                     int unsigned min_bytes, int unsigned min_datagrams);
    byte_q_t     f;
    int unsigned sent_bytes;
    int unsigned sent_datagrams;
    int unsigned pick;
    int unsigned payload;
    logic [4:0]  ver;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent_bytes     = 0;
    sent_datagrams = 0;
    while (sent_bytes < min_bytes || sent_datagrams < min_datagrams) begin
      pick    = $urandom_range(99);
      payload = ($urandom_range(9) < 8) ? $urandom_range(16) : $urandom_range(300, 17);
      if (pick < 65) begin
        build_datagram(f, -1, fhpc_pkg::HDR_VERSION, 1'b0, payload);
      end else if (pick < 75) begin
        ver = 5'($urandom_range(31));
        if (ver == fhpc_pkg::HDR_VERSION) begin
          ver = ver + 5'd1;
        end
        build_datagram(f, -1, ver, 1'b0, payload);
      end else if (pick < 85) begin
        build_datagram(f, -1, fhpc_pkg::HDR_VERSION, 1'b1, payload);
      end else begin
        f = {};
        repeat (($urandom_range(9) < 3) ? 1 : $urandom_range(fhpc_pkg::HDR_BYTES - 1, 1))
        begin
          f.push_back(8'($urandom));
        end
      end
      send_datagram(f);
      sent_bytes += f.size();
      sent_datagrams++;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_runt_datagrams();
    test_good_headers();
    test_check_order();
    test_random_traffic(0, 0, 70, 1);
    test_random_traffic(58, 0, 70, 1);
    test_random_traffic(0, 58, 70, 1);
    test_random_traffic(15, 15, 70, 1);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
